// ===== design/tpg_pkg.sv =====
// Shared types, codes and constants of the tape pulse generator.
`default_nettype none

package tpg_pkg;

  // Default width of the elapsed-cycle counter.
  localparam int unsigned ELAPSED_WIDTH_DEF = 24;

  // Configuration port geometry: eight registers, 32-bit data, byte addressed.
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 5;

  // Widths of the configured quantities.
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned COUNT_W = 14;
  localparam int unsigned PAUSE_W = 24;

  // Register reset values.
  localparam logic [PULSE_W-1:0] PILOT_LEN_RST    = 16'd2168;
  localparam logic [PULSE_W-1:0] SYNC1_LEN_RST    = 16'd667;
  localparam logic [PULSE_W-1:0] SYNC2_LEN_RST    = 16'd735;
  localparam logic [PULSE_W-1:0] BIT0_LEN_RST     = 16'd855;
  localparam logic [PULSE_W-1:0] BIT1_LEN_RST     = 16'd1710;
  localparam logic [COUNT_W-1:0] HDR_PILOT_RST    = 14'd8063;
  localparam logic [COUNT_W-1:0] DATA_PILOT_RST   = 14'd3223;
  localparam logic [PAUSE_W-1:0] PAUSE_LEN_RST    = 24'd3500000;

  // Index of the first bit sent of each byte (MSB first).
  localparam logic [2:0] BIT_FIRST = 3'd7;

  // Tape phase codes.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PILOT = 3'd1,
    PH_SYNC1 = 3'd2,
    PH_SYNC2 = 3'd3,
    PH_DATA  = 3'd4,
    PH_PAUSE = 3'd5
  } phase_t;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_BEGIN  = 2'd1,
    ACT_SUPPLY = 2'd2,
    ACT_TOGGLE = 2'd3
  } action_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PILOT_LEN  = 3'd0,
    REG_SYNC1_LEN  = 3'd1,
    REG_SYNC2_LEN  = 3'd2,
    REG_BIT0_LEN   = 3'd3,
    REG_BIT1_LEN   = 3'd4,
    REG_HDR_PILOT  = 3'd5,
    REG_DATA_PILOT = 3'd6,
    REG_PAUSE_LEN  = 3'd7
  } reg_idx_t;

  // Input transaction payload.
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  elapsed_cycles;
    logic [7:0]  data_byte;
    logic [15:0] block_length;
    logic [7:0]  block_flag;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic        ear_level;
    logic [2:0]  tape_phase;
    logic        byte_wanted;
    logic        block_finished;
    logic        underrun;
    logic [15:0] bytes_played;
  } out_item_t;

  // Classified command handed from the front end to the engine.
  typedef struct packed {
    action_t     action;
    logic [7:0]  cycles;
    logic [7:0]  data_byte;
    logic [15:0] block_length;
    logic        header;
  } cmd_t;

  // Current configuration as seen by the engine.
  typedef struct packed {
    logic [PULSE_W-1:0] pilot_pulse_len;
    logic [PULSE_W-1:0] sync1_len;
    logic [PULSE_W-1:0] sync2_len;
    logic [PULSE_W-1:0] bit0_len;
    logic [PULSE_W-1:0] bit1_len;
    logic [COUNT_W-1:0] header_pilot_count;
    logic [COUNT_W-1:0] data_pilot_count;
    logic [PAUSE_W-1:0] pause_len;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/tpg_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module tpg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tpg_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [tpg_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [tpg_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output tpg_pkg::cfg_t                        cfg
);

  tpg_pkg::cfg_t     cfg_r;
  tpg_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = tpg_pkg::reg_idx_t'(paddr[tpg_pkg::CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pilot_pulse_len    <= tpg_pkg::PILOT_LEN_RST;
      cfg_r.sync1_len          <= tpg_pkg::SYNC1_LEN_RST;
      cfg_r.sync2_len          <= tpg_pkg::SYNC2_LEN_RST;
      cfg_r.bit0_len           <= tpg_pkg::BIT0_LEN_RST;
      cfg_r.bit1_len           <= tpg_pkg::BIT1_LEN_RST;
      cfg_r.header_pilot_count <= tpg_pkg::HDR_PILOT_RST;
      cfg_r.data_pilot_count   <= tpg_pkg::DATA_PILOT_RST;
      cfg_r.pause_len          <= tpg_pkg::PAUSE_LEN_RST;
    end else if (wr_en) begin
      unique case (idx)
        tpg_pkg::REG_PILOT_LEN:  cfg_r.pilot_pulse_len <= pwdata[tpg_pkg::PULSE_W-1:0];
        tpg_pkg::REG_SYNC1_LEN:  cfg_r.sync1_len       <= pwdata[tpg_pkg::PULSE_W-1:0];
        tpg_pkg::REG_SYNC2_LEN:  cfg_r.sync2_len       <= pwdata[tpg_pkg::PULSE_W-1:0];
        tpg_pkg::REG_BIT0_LEN:   cfg_r.bit0_len        <= pwdata[tpg_pkg::PULSE_W-1:0];
        tpg_pkg::REG_BIT1_LEN:   cfg_r.bit1_len        <= pwdata[tpg_pkg::PULSE_W-1:0];
        tpg_pkg::REG_HDR_PILOT:  cfg_r.header_pilot_count <= pwdata[tpg_pkg::COUNT_W-1:0];
        tpg_pkg::REG_DATA_PILOT: cfg_r.data_pilot_count   <= pwdata[tpg_pkg::COUNT_W-1:0];
        tpg_pkg::REG_PAUSE_LEN:  cfg_r.pause_len       <= pwdata[tpg_pkg::PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is the addressed register, zero extended.
  always_comb begin
    unique case (idx)
      tpg_pkg::REG_PILOT_LEN:  prdata = tpg_pkg::CFG_DATA_W'(cfg_r.pilot_pulse_len);
      tpg_pkg::REG_SYNC1_LEN:  prdata = tpg_pkg::CFG_DATA_W'(cfg_r.sync1_len);
      tpg_pkg::REG_SYNC2_LEN:  prdata = tpg_pkg::CFG_DATA_W'(cfg_r.sync2_len);
      tpg_pkg::REG_BIT0_LEN:   prdata = tpg_pkg::CFG_DATA_W'(cfg_r.bit0_len);
      tpg_pkg::REG_BIT1_LEN:   prdata = tpg_pkg::CFG_DATA_W'(cfg_r.bit1_len);
      tpg_pkg::REG_HDR_PILOT:  prdata = tpg_pkg::CFG_DATA_W'(cfg_r.header_pilot_count);
      tpg_pkg::REG_DATA_PILOT: prdata = tpg_pkg::CFG_DATA_W'(cfg_r.data_pilot_count);
      tpg_pkg::REG_PAUSE_LEN:  prdata = tpg_pkg::CFG_DATA_W'(cfg_r.pause_len);
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/tpg_front.sv =====
// Front end: accepts input transactions, classifies them and queues commands.
`default_nettype none

module tpg_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tpg_pkg::in_item_t in_item,
  output logic                   full,
  output tpg_pkg::cmd_t          cmd_head,
  output logic                   cmd_valid,
  input  wire logic              cmd_take
);

  tpg_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic [1:0]    cnt_nxt;
  logic          do_push;
  logic          do_pop;
  tpg_pkg::cmd_t cmd_in;

  // Classify the transaction: decode the action and reduce the flag to a header mark.
  always_comb begin
    cmd_in.action       = tpg_pkg::action_t'(in_item.action);
    cmd_in.cycles       = in_item.elapsed_cycles;
    cmd_in.data_byte    = in_item.data_byte;
    cmd_in.block_length = in_item.block_length;
    cmd_in.header       = (in_item.block_flag == 8'd0);
  end

  assign full      = cnt_r[1];
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_head  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Two-entry command queue between front end and engine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== design/tpg_engine.sv =====
// Back end: executes commands against the tape state and forms one result each.
`default_nettype none

module tpg_engine #(
  parameter int unsigned ELAPSED_WIDTH = tpg_pkg::ELAPSED_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tpg_pkg::cfg_t      cfg,
  input  wire tpg_pkg::cmd_t      cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_take,
  input  wire logic               res_full,
  output logic                    res_push,
  output tpg_pkg::out_item_t      res
);

  localparam int unsigned EW    = ELAPSED_WIDTH;
  localparam int unsigned CMP_W = (EW > tpg_pkg::PAUSE_W) ? EW : tpg_pkg::PAUSE_W;
  localparam int unsigned CW    = tpg_pkg::COUNT_W;
  localparam int unsigned PW    = tpg_pkg::PULSE_W;

  tpg_pkg::phase_t phase_r, phase_nxt;
  logic            running_r, running_nxt;
  logic [EW-1:0]   elapsed_r, elapsed_nxt;
  logic            level_r, level_nxt;
  logic [CW-1:0]   pilot_done_r, pilot_done_nxt;
  logic [CW-1:0]   pilot_target_r, pilot_target_nxt;
  logic            half_bit_r, half_bit_nxt;
  logic [2:0]      bit_index_r, bit_index_nxt;
  logic [7:0]      cur_byte_r, cur_byte_nxt;
  logic            cur_valid_r, cur_valid_nxt;
  logic [7:0]      next_byte_r, next_byte_nxt;
  logic            next_valid_r, next_valid_nxt;
  logic [15:0]     byte_count_r, byte_count_nxt;
  logic [15:0]     length_r, length_nxt;
  logic [PW-1:0]   pulse_limit_r, pulse_limit_nxt;

  logic            fire;
  logic [EW:0]     sum;
  logic [EW-1:0]   el_sat;
  logic [PW-1:0]   data_lim;
  logic [PW-1:0]   cur_lim;
  logic [CMP_W-1:0] limit;
  logic            passed;
  logic            tick_live;
  logic [CW-1:0]   pilot_inc;
  logic [15:0]     count_inc;
  logic [16:0]     supplied;
  logic            room;
  logic [16:0]     supplied_nxt;

  assign fire     = cmd_valid && !res_full;
  assign cmd_take = fire;
  assign res_push = fire;

  // Shared tick datapath: saturating add and compare against the active limit.
  always_comb begin
    sum       = {1'b0, elapsed_r} + (EW+1)'(cmd.cycles);
    el_sat    = sum[EW] ? {EW{1'b1}} : sum[EW-1:0];
    data_lim  = cur_byte_r[bit_index_r] ? cfg.bit1_len : cfg.bit0_len;
    cur_lim   = (phase_r == tpg_pkg::PH_DATA) ? data_lim : pulse_limit_r;
    limit     = (phase_r == tpg_pkg::PH_PAUSE) ? CMP_W'(cfg.pause_len) : CMP_W'(cur_lim);
    passed    = CMP_W'(el_sat) > limit;
    tick_live = running_r && (phase_r != tpg_pkg::PH_IDLE) &&
                !((phase_r == tpg_pkg::PH_DATA) && !cur_valid_r);
    pilot_inc = pilot_done_r + CW'(1);
    count_inc = byte_count_r + 16'd1;
    supplied  = {1'b0, byte_count_r} + 17'(cur_valid_r) + 17'(next_valid_r);
    room      = supplied < {1'b0, length_r};
  end

  // Next state for the command at the head of the queue.
  always_comb begin
    phase_nxt        = phase_r;
    running_nxt      = running_r;
    elapsed_nxt      = elapsed_r;
    level_nxt        = level_r;
    pilot_done_nxt   = pilot_done_r;
    pilot_target_nxt = pilot_target_r;
    half_bit_nxt     = half_bit_r;
    bit_index_nxt    = bit_index_r;
    cur_byte_nxt     = cur_byte_r;
    cur_valid_nxt    = cur_valid_r;
    next_byte_nxt    = next_byte_r;
    next_valid_nxt   = next_valid_r;
    byte_count_nxt   = byte_count_r;
    length_nxt       = length_r;
    pulse_limit_nxt  = pulse_limit_r;

    unique case (cmd.action)
      tpg_pkg::ACT_TICK: begin
        if (tick_live) begin
          if (phase_r == tpg_pkg::PH_DATA) begin
            pulse_limit_nxt = data_lim;
          end
          if (!passed) begin
            elapsed_nxt = el_sat;
          end else begin
            elapsed_nxt = '0;
            unique case (phase_r)
              tpg_pkg::PH_PILOT: begin
                level_nxt      = !level_r;
                pilot_done_nxt = pilot_inc;
                if (pilot_inc >= pilot_target_r) begin
                  pilot_done_nxt  = '0;
                  phase_nxt       = tpg_pkg::PH_SYNC1;
                  pulse_limit_nxt = cfg.sync1_len;
                end
              end
              tpg_pkg::PH_SYNC1: begin
                level_nxt       = !level_r;
                phase_nxt       = tpg_pkg::PH_SYNC2;
                pulse_limit_nxt = cfg.sync2_len;
              end
              tpg_pkg::PH_SYNC2: begin
                half_bit_nxt  = 1'b0;
                bit_index_nxt = tpg_pkg::BIT_FIRST;
                if (byte_count_r >= length_r) begin
                  phase_nxt = tpg_pkg::PH_PAUSE;
                  level_nxt = 1'b0;
                end else begin
                  phase_nxt = tpg_pkg::PH_DATA;
                  level_nxt = !level_r;
                end
              end
              tpg_pkg::PH_DATA: begin
                level_nxt = !level_r;
                if (!half_bit_r) begin
                  half_bit_nxt = 1'b1;
                end else begin
                  half_bit_nxt = 1'b0;
                  if (bit_index_r != 3'd0) begin
                    bit_index_nxt = bit_index_r - 3'd1;
                  end else begin
                    // Last half of the last bit: the byte is done, shift the pair.
                    bit_index_nxt  = tpg_pkg::BIT_FIRST;
                    byte_count_nxt = count_inc;
                    cur_byte_nxt   = next_byte_r;
                    cur_valid_nxt  = next_valid_r;
                    next_byte_nxt  = '0;
                    next_valid_nxt = 1'b0;
                    if (count_inc >= length_r) begin
                      phase_nxt = tpg_pkg::PH_PAUSE;
                      level_nxt = 1'b0;
                    end
                  end
                end
              end
              default: begin
                // End of the pause.
                phase_nxt = tpg_pkg::PH_IDLE;
                level_nxt = 1'b0;
              end
            endcase
          end
        end
      end
      tpg_pkg::ACT_BEGIN: begin
        length_nxt       = cmd.block_length;
        pilot_target_nxt = cmd.header ? cfg.header_pilot_count : cfg.data_pilot_count;
        phase_nxt        = tpg_pkg::PH_PILOT;
        running_nxt      = 1'b1;
        elapsed_nxt      = '0;
        level_nxt        = 1'b0;
        pilot_done_nxt   = '0;
        half_bit_nxt     = 1'b0;
        bit_index_nxt    = tpg_pkg::BIT_FIRST;
        byte_count_nxt   = '0;
        cur_byte_nxt     = '0;
        cur_valid_nxt    = 1'b0;
        next_byte_nxt    = '0;
        next_valid_nxt   = 1'b0;
        pulse_limit_nxt  = cfg.pilot_pulse_len;
      end
      tpg_pkg::ACT_SUPPLY: begin
        if (room) begin
          if (!cur_valid_r) begin
            cur_byte_nxt  = cmd.data_byte;
            cur_valid_nxt = 1'b1;
          end else if (!next_valid_r) begin
            next_byte_nxt  = cmd.data_byte;
            next_valid_nxt = 1'b1;
          end
        end
      end
      tpg_pkg::ACT_TOGGLE: begin
        if (running_r) begin
          running_nxt = 1'b0;
        end else begin
          running_nxt = 1'b1;
          elapsed_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // Result transaction, taken from the state after the command.
  always_comb begin
    supplied_nxt = {1'b0, byte_count_nxt} + 17'(cur_valid_nxt) + 17'(next_valid_nxt);
    res.ear_level      = (phase_nxt == tpg_pkg::PH_IDLE || phase_nxt == tpg_pkg::PH_PAUSE) ?
                         1'b0 : level_nxt;
    res.tape_phase     = phase_nxt;
    res.byte_wanted    = !next_valid_nxt && (supplied_nxt < {1'b0, length_nxt});
    res.block_finished = (phase_nxt == tpg_pkg::PH_IDLE);
    res.underrun       = (phase_nxt == tpg_pkg::PH_DATA) && !cur_valid_nxt;
    res.bytes_played   = byte_count_nxt;
  end

  // State registers advance once per executed command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= tpg_pkg::PH_IDLE;
      running_r      <= 1'b0;
      elapsed_r      <= '0;
      level_r        <= 1'b0;
      pilot_done_r   <= '0;
      pilot_target_r <= '0;
      half_bit_r     <= 1'b0;
      bit_index_r    <= tpg_pkg::BIT_FIRST;
      cur_byte_r     <= '0;
      cur_valid_r    <= 1'b0;
      next_byte_r    <= '0;
      next_valid_r   <= 1'b0;
      byte_count_r   <= '0;
      length_r       <= '0;
      pulse_limit_r  <= '0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      running_r      <= running_nxt;
      elapsed_r      <= elapsed_nxt;
      level_r        <= level_nxt;
      pilot_done_r   <= pilot_done_nxt;
      pilot_target_r <= pilot_target_nxt;
      half_bit_r     <= half_bit_nxt;
      bit_index_r    <= bit_index_nxt;
      cur_byte_r     <= cur_byte_nxt;
      cur_valid_r    <= cur_valid_nxt;
      next_byte_r    <= next_byte_nxt;
      next_valid_r   <= next_valid_nxt;
      byte_count_r   <= byte_count_nxt;
      length_r       <= length_nxt;
      pulse_limit_r  <= pulse_limit_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/tpg_outq.sv =====
// Result queue: holds finished results until the consumer pops them.
`default_nettype none

module tpg_outq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_push,
  input  wire tpg_pkg::out_item_t res,
  output logic                    res_full,
  input  wire logic               pop,
  output logic                    empty,
  output tpg_pkg::out_item_t      out_item
);

  tpg_pkg::out_item_t slot_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         cnt_r;
  logic [1:0]         cnt_nxt;
  logic               do_pop;

  assign res_full = cnt_r[1];
  assign empty    = (cnt_r == 2'd0);
  assign out_item = slot_r[rd_ptr_r];
  assign do_pop   = pop && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !res_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/tape_pulse_generator.sv =====
// Top level of the tape pulse generator: register file, front end, engine, result queue.
//
//  Channel  | Ports                                        | Transaction when
//  ---------+----------------------------------------------+-------------------------------
//  input    | push, full, in_item                          | push && !full
//  result   | pop, empty, out_item                         | pop && !empty
//  config   | psel, penable, pwrite, paddr, pwdata, prdata | psel && penable && pwrite && pready
//
// One transaction per clock is sustained while the result queue is not full.
// An accepted input is registered in the command queue, then its result is registered in
// the result queue, where it is visible and can be popped.
// The engine's tick path (one saturating add and one compare) sets the cycle.
// Reset (rst_n low, synchronous) empties both queues and returns the tape to idle.
// A full result queue stalls the engine; the command queue then fills and raises full.
`default_nettype none

module tape_pulse_generator #(
  parameter int unsigned ELAPSED_WIDTH = tpg_pkg::ELAPSED_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire tpg_pkg::in_item_t               in_item,
  input  wire logic                            pop,
  output logic                                 empty,
  output tpg_pkg::out_item_t                   out_item,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tpg_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [tpg_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [tpg_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready
);

  tpg_pkg::cfg_t      cfg;
  tpg_pkg::cmd_t      cmd_head;
  logic               cmd_valid;
  logic               cmd_take;
  logic               res_full;
  logic               res_push;
  tpg_pkg::out_item_t res;

  tpg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cmd_head  (cmd_head),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take)
  );

  tpg_engine #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd_head),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  tpg_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

  // The engine never writes a result into a full result queue.
  assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
    else $error("result written into a full result queue");

  // The engine only takes a command that is actually queued.
  assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> cmd_valid)
    else $error("command taken from an empty command queue");

  // An idle or pausing tape is silent and never reports an underrun.
  assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_item.tape_phase == tpg_pkg::PH_IDLE ||
                out_item.tape_phase == tpg_pkg::PH_PAUSE))
    |-> (!out_item.ear_level && !out_item.underrun))
    else $error("level or underrun reported outside an active block");

  // Every executed command shows up as a queued result on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (res_push && !pop) |=> !empty)
    else $error("executed command left no result");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the tape pulse generator: stimulus, tape predictor and checks.
`timescale 1ns / 100ps

// Tracks the tape state from accepted commands and checks each result against it.
class tape_scoreboard;
  localparam int EW = tpg_pkg::ELAPSED_WIDTH_DEF;

  tpg_pkg::cfg_t               cfg;
  tpg_pkg::phase_t             phase;
  bit                          running;
  bit                          level;
  bit                          half_bit;
  bit                          cur_valid;
  bit                          nxt_valid;
  logic [EW-1:0]               elapsed;
  logic [tpg_pkg::COUNT_W-1:0] pilot_done;
  logic [tpg_pkg::COUNT_W-1:0] pilot_target;
  logic [2:0]                  bit_index;
  logic [7:0]                  cur_byte;
  logic [7:0]                  nxt_byte;
  logic [15:0]                 byte_count;
  logic [15:0]                 length_held;
  logic [tpg_pkg::PULSE_W-1:0] pulse_limit;
  tpg_pkg::out_item_t          tape_status_q[$];
  int                          errors;

  function new();
    cfg = '{tpg_pkg::PILOT_LEN_RST, tpg_pkg::SYNC1_LEN_RST, tpg_pkg::SYNC2_LEN_RST,
            tpg_pkg::BIT0_LEN_RST, tpg_pkg::BIT1_LEN_RST, tpg_pkg::HDR_PILOT_RST,
            tpg_pkg::DATA_PILOT_RST, tpg_pkg::PAUSE_LEN_RST};
    phase = tpg_pkg::PH_IDLE;
    running = 0;
    level = 0;
    half_bit = 0;
    cur_valid = 0;
    nxt_valid = 0;
    elapsed = '0;
    pilot_done = '0;
    pilot_target = '0;
    bit_index = tpg_pkg::BIT_FIRST;
    cur_byte = '0;
    nxt_byte = '0;
    byte_count = '0;
    length_held = '0;
    pulse_limit = '0;
    errors = 0;
  endfunction

  function void write_reg(tpg_pkg::reg_idx_t idx, logic [31:0] value);
    case (idx)
      tpg_pkg::REG_PILOT_LEN:  cfg.pilot_pulse_len = value[tpg_pkg::PULSE_W-1:0];
      tpg_pkg::REG_SYNC1_LEN:  cfg.sync1_len = value[tpg_pkg::PULSE_W-1:0];
      tpg_pkg::REG_SYNC2_LEN:  cfg.sync2_len = value[tpg_pkg::PULSE_W-1:0];
      tpg_pkg::REG_BIT0_LEN:   cfg.bit0_len = value[tpg_pkg::PULSE_W-1:0];
      tpg_pkg::REG_BIT1_LEN:   cfg.bit1_len = value[tpg_pkg::PULSE_W-1:0];
      tpg_pkg::REG_HDR_PILOT:  cfg.header_pilot_count = value[tpg_pkg::COUNT_W-1:0];
      tpg_pkg::REG_DATA_PILOT: cfg.data_pilot_count = value[tpg_pkg::COUNT_W-1:0];
      default:                 cfg.pause_len = value[tpg_pkg::PAUSE_W-1:0];
    endcase
  endfunction

  function int pending();
    return tape_status_q.size();
  endfunction

  // The block still has bytes that were never handed over and the spare slot is free.
  function bit wants_byte();
    return !nxt_valid && (int'(byte_count) + cur_valid + nxt_valid < int'(length_held));
  endfunction

  function void enter_pause();
    phase = tpg_pkg::PH_PAUSE;
    level = 0;
    elapsed = '0;
  endfunction

  // Adds a tick's elapsed CPU time and, once the current limit is passed, toggles the level or ends the pause.
  function void advance(logic [7:0] cycles);
    logic [EW:0]   total;
    logic [EW-1:0] limit;
    if (!running || phase == tpg_pkg::PH_IDLE) return;
    if (phase == tpg_pkg::PH_DATA) begin
      // With no byte held the generator stalls and the level holds.
      if (!cur_valid) return;
      pulse_limit = cur_byte[bit_index] ? cfg.bit1_len : cfg.bit0_len;
    end
    total = {1'b0, elapsed} + (EW+1)'(cycles);
    elapsed = total[EW] ? '1 : total[EW-1:0];
    limit = (phase == tpg_pkg::PH_PAUSE) ? EW'(cfg.pause_len) : EW'(pulse_limit);
    if (elapsed <= limit) return;
    elapsed = '0;
    case (phase)
      tpg_pkg::PH_PILOT: begin
        level = !level;
        pilot_done++;
        if (pilot_done >= pilot_target) begin
          pilot_done = '0;
          phase = tpg_pkg::PH_SYNC1;
          pulse_limit = cfg.sync1_len;
        end
      end
      tpg_pkg::PH_SYNC1: begin
        level = !level;
        phase = tpg_pkg::PH_SYNC2;
        pulse_limit = cfg.sync2_len;
      end
      tpg_pkg::PH_SYNC2: begin
        level = !level;
        half_bit = 0;
        bit_index = tpg_pkg::BIT_FIRST;
        if (byte_count >= length_held) enter_pause();
        else phase = tpg_pkg::PH_DATA;
      end
      tpg_pkg::PH_DATA: begin
        level = !level;
        if (!half_bit) begin
          half_bit = 1;
        end else begin
          half_bit = 0;
          if (bit_index != 3'd0) begin
            bit_index--;
          end else begin
            // Last bit of the byte is out: move the spare byte up.
            bit_index = tpg_pkg::BIT_FIRST;
            byte_count++;
            cur_byte = nxt_byte;
            cur_valid = nxt_valid;
            nxt_byte = '0;
            nxt_valid = 0;
            if (byte_count >= length_held) enter_pause();
          end
        end
      end
      default: begin
        phase = tpg_pkg::PH_IDLE;
        level = 0;
      end
    endcase
  endfunction

  // Applies one accepted command and queues the status it should produce.
  function void note_input(tpg_pkg::in_item_t it);
    tpg_pkg::out_item_t want;
    case (tpg_pkg::action_t'(it.action))
      tpg_pkg::ACT_TICK: advance(it.elapsed_cycles);
      tpg_pkg::ACT_BEGIN: begin
        length_held = it.block_length;
        pilot_target = (it.block_flag != 8'd0) ? cfg.data_pilot_count :
                                                 cfg.header_pilot_count;
        phase = tpg_pkg::PH_PILOT;
        running = 1;
        elapsed = '0;
        level = 0;
        pilot_done = '0;
        half_bit = 0;
        bit_index = tpg_pkg::BIT_FIRST;
        byte_count = '0;
        cur_byte = '0;
        cur_valid = 0;
        nxt_byte = '0;
        nxt_valid = 0;
        pulse_limit = cfg.pilot_pulse_len;
      end
      tpg_pkg::ACT_SUPPLY: begin
        if (int'(byte_count) + cur_valid + nxt_valid < int'(length_held)) begin
          if (!cur_valid) begin
            cur_byte = it.data_byte;
            cur_valid = 1;
          end else if (!nxt_valid) begin
            nxt_byte = it.data_byte;
            nxt_valid = 1;
          end
        end
      end
      default: begin
        if (running) begin
          running = 0;
        end else begin
          running = 1;
          elapsed = '0;
        end
      end
    endcase
    want.ear_level = (phase == tpg_pkg::PH_IDLE || phase == tpg_pkg::PH_PAUSE) ? 1'b0 : level;
    want.tape_phase = phase;
    want.byte_wanted = wants_byte();
    want.block_finished = (phase == tpg_pkg::PH_IDLE);
    want.underrun = (phase == tpg_pkg::PH_DATA && !cur_valid);
    want.bytes_played = byte_count;
    tape_status_q.push_back(want);
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
    if (want !== seen) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
    end
  endfunction

  function void check_result(tpg_pkg::out_item_t seen);
    tpg_pkg::out_item_t want;
    if (tape_status_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result transaction %0h", $time, seen);
      return;
    end
    want = tape_status_q.pop_front();
    compare_field("ear_level", 16'(want.ear_level), 16'(seen.ear_level));
    compare_field("tape_phase", 16'(want.tape_phase), 16'(seen.tape_phase));
    compare_field("byte_wanted", 16'(want.byte_wanted), 16'(seen.byte_wanted));
    compare_field("block_finished", 16'(want.block_finished), 16'(seen.block_finished));
    compare_field("underrun", 16'(want.underrun), 16'(seen.underrun));
    compare_field("bytes_played", want.bytes_played, seen.bytes_played);
  endfunction
endclass

module tb;
  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           push = 1'b0;
  logic                           pop = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [tpg_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [tpg_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [tpg_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           full;
  logic                           empty;
  tpg_pkg::in_item_t              in_item = '0;
  tpg_pkg::out_item_t             out_item;

  int             idle_pct = 0;
  int             stall_pct = 0;
  bit             hold_req = 0;
  tape_scoreboard sb;

  tape_pulse_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one command and returns at the edge where it was taken.
  task send_item(tpg_pkg::in_item_t it);
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(it);
  endtask

  task send_op(tpg_pkg::action_t act, logic [7:0] cycles, logic [7:0] data_v,
               logic [15:0] len, logic [7:0] flag);
    tpg_pkg::in_item_t it;
    it.action = act;
    it.elapsed_cycles = cycles;
    it.data_byte = data_v;
    it.block_length = len;
    it.block_flag = flag;
    send_item(it);
  endtask

  // Stops offering commands until every queued status has been read back.
  task drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task write_cfg(tpg_pkg::reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Writes follow each other back to back; the port goes quiet after the last one.
  task load_cfg(tpg_pkg::cfg_t c);
    write_cfg(tpg_pkg::REG_PILOT_LEN, 32'(c.pilot_pulse_len));
    write_cfg(tpg_pkg::REG_SYNC1_LEN, 32'(c.sync1_len));
    write_cfg(tpg_pkg::REG_SYNC2_LEN, 32'(c.sync2_len));
    write_cfg(tpg_pkg::REG_BIT0_LEN, 32'(c.bit0_len));
    write_cfg(tpg_pkg::REG_BIT1_LEN, 32'(c.bit1_len));
    write_cfg(tpg_pkg::REG_HDR_PILOT, 32'(c.header_pilot_count));
    write_cfg(tpg_pkg::REG_DATA_PILOT, 32'(c.data_pilot_count));
    write_cfg(tpg_pkg::REG_PAUSE_LEN, 32'(c.pause_len));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic tpg_pkg::cfg_t short_cfg(int max_len, int max_count, int max_pause);
    tpg_pkg::cfg_t c;
    c.pilot_pulse_len = tpg_pkg::PULSE_W'($urandom_range(1, max_len));
    c.sync1_len = tpg_pkg::PULSE_W'($urandom_range(1, max_len));
    c.sync2_len = tpg_pkg::PULSE_W'($urandom_range(1, max_len));
    c.bit0_len = tpg_pkg::PULSE_W'($urandom_range(1, max_len));
    c.bit1_len = tpg_pkg::PULSE_W'($urandom_range(1, max_len));
    c.header_pilot_count = tpg_pkg::COUNT_W'($urandom_range(1, max_count));
    c.data_pilot_count = tpg_pkg::COUNT_W'($urandom_range(1, max_count));
    c.pause_len = tpg_pkg::PAUSE_W'($urandom_range(0, max_pause));
    return c;
  endfunction

  // Mostly well-formed tape traffic: begin when idle, feed bytes on request,
  // resume when paused; the rest is ticks plus stray commands.
  function automatic tpg_pkg::in_item_t pick_item(bit long_ticks);
    tpg_pkg::in_item_t it;
    tpg_pkg::action_t  act;
    int                r;
    int                r_len;
    it.elapsed_cycles = 8'($urandom);
    it.data_byte = 8'($urandom);
    it.block_length = 16'($urandom);
    it.block_flag = 8'($urandom);
    r = $urandom_range(99);
    if (!sb.running && sb.phase != tpg_pkg::PH_IDLE && r < 50) act = tpg_pkg::ACT_TOGGLE;
    else if (sb.phase == tpg_pkg::PH_IDLE && r < 70) act = tpg_pkg::ACT_BEGIN;
    else if (sb.wants_byte() && r < 40) act = tpg_pkg::ACT_SUPPLY;
    else if (r < 2) act = tpg_pkg::ACT_BEGIN;
    else if (r < 5) act = tpg_pkg::ACT_TOGGLE;
    else if (r < 9) act = tpg_pkg::ACT_SUPPLY;
    else act = tpg_pkg::ACT_TICK;
    it.action = act;
    if (act == tpg_pkg::ACT_BEGIN) begin
      r_len = $urandom_range(99);
      if (r_len < 85) it.block_length = 16'($urandom_range(0, 5));
      else if (r_len < 95) it.block_length = 16'($urandom_range(6, 40));
      if ($urandom_range(99) < 30) it.block_flag = '0;
    end
    if (act == tpg_pkg::ACT_TICK && long_ticks && $urandom_range(1) == 1) begin
      it.elapsed_cycles = 8'hFF;
    end
    return it;
  endfunction

  task run_items(int n, bit long_ticks);
    for (int i = 0; i < n; i++) begin
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      send_item(pick_item(long_ticks));
    end
  endtask

  // Result side: checks every read and stalls as the current mode asks.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) sb.check_result(out_item);
      if (hold_req) begin
        hold_req = 0;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : main
    tpg_pkg::cfg_t c;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short pulses so that each long tick moves the tape on; zero data pilot count and zero pause.
    load_cfg('{16'd3, 16'd2, 16'd1, 16'd1, 16'd2, 14'd2, 14'd0, 24'd0});
    // Commands while idle are ignored, but the toggle still flips the running flag.
    send_op(tpg_pkg::ACT_TICK, 8'hFF, 8'h00, 16'd3, 8'h00);
    send_op(tpg_pkg::ACT_SUPPLY, 8'h00, 8'h12, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TOGGLE, 8'h00, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TOGGLE, 8'h00, 8'h00, 16'd0, 8'h00);
    // Header block of zero length: pilot, both syncs, then straight into the pause.
    send_op(tpg_pkg::ACT_BEGIN, 8'h00, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TICK, 8'h00, 8'hFF, 16'hFFFF, 8'hFF);
    repeat (4) send_op(tpg_pkg::ACT_TICK, 8'hFF, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TICK, 8'h00, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TICK, 8'h01, 8'h00, 16'd0, 8'h00);
    // Data block with a zero pilot target, paused and resumed, then starved of bytes.
    send_op(tpg_pkg::ACT_BEGIN, 8'h00, 8'h00, 16'd1, 8'h80);
    send_op(tpg_pkg::ACT_TOGGLE, 8'h00, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TICK, 8'hFF, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TOGGLE, 8'h00, 8'h00, 16'd0, 8'h00);
    repeat (4) send_op(tpg_pkg::ACT_TICK, 8'hFF, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_SUPPLY, 8'h00, 8'h80, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_SUPPLY, 8'h00, 8'hFF, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_TICK, 8'hFF, 8'h00, 16'd0, 8'h00);
    // Restart mid-block with the longest block; the third byte finds both slots full.
    send_op(tpg_pkg::ACT_BEGIN, 8'h00, 8'h00, 16'hFFFF, 8'hFF);
    send_op(tpg_pkg::ACT_SUPPLY, 8'h00, 8'h00, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_SUPPLY, 8'h00, 8'hFF, 16'd0, 8'h00);
    send_op(tpg_pkg::ACT_SUPPLY, 8'h00, 8'h55, 16'd0, 8'h00);

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin c = short_cfg(300, 6, 1500); idle_pct = 0;  stall_pct = 0;  end
        1: begin c = short_cfg(300, 6, 1500); idle_pct = 45; stall_pct = 0;  end
        2: begin c = short_cfg(600, 4, 800);  idle_pct = 0;  stall_pct = 45; end
        3: begin
          c = '{16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1, 14'h3FFF, 14'd1, 24'hFFFFFF};
          idle_pct = 10;
          stall_pct = 10;
        end
        default: begin c = short_cfg(300, 6, 1500); idle_pct = 0; stall_pct = 0; end
      endcase
      load_cfg(c);
      // Long receiver hold-off while commands keep coming, so both queues fill up.
      if (p == 0) hold_req = 1;
      if (p == 3) begin
        // Long first sync pulse, then a pause that is far longer than the rest of the run.
        send_op(tpg_pkg::ACT_BEGIN, 8'h00, 8'h00, 16'd0, 8'h01);
        repeat (280) send_op(tpg_pkg::ACT_TICK, 8'hFF, 8'h00, 16'd0, 8'h00);
      end
      run_items(190, p == 3);
      if (p == 1) drain();
      run_items(190, p == 3);
    end

    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #30000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
